// ----- design/dfgh_pkg.sv -----
// Shared constants, types and helper functions for the dual FNV-1a identifier hash.
// No dependencies; every other design file references this package by scoped name.
package dfgh_pkg;

  localparam int unsigned HashW = 64;
  localparam int unsigned ByteW = 8;

  localparam logic [HashW-1:0] FnvOffset   = 64'hcbf2_9ce4_8422_2325;
  localparam logic [HashW-1:0] SeedFirst   = 64'h4e4c_535f_4755_4944;
  localparam logic [HashW-1:0] SeedSecond  = 64'h6469_7567_5f53_4c4e;
  localparam logic [HashW-1:0] StartFirst  = FnvOffset ^ SeedFirst;
  localparam logic [HashW-1:0] StartSecond = FnvOffset ^ SeedSecond;

  localparam logic [3:0] UuidVersion = 4'b0100;
  localparam logic [1:0] UuidVariant = 2'b10;

  typedef struct packed {
    logic advance;  // the held item moves on this cycle
    logic take;     // the held item carries a byte
    logic restart;  // the held item ends the label
  } lane_ctrl_t;

  // Multiply by the FNV-64 prime 0x100000001b3 modulo 2^64 as a shift-add sum.
  function automatic logic [HashW-1:0] fnv_mul(input logic [HashW-1:0] h);
    logic [HashW-1:0] acc;
    acc = (h << 40) + (h << 8) + (h << 7) + (h << 5) + (h << 4) + (h << 1) + h;
    return acc;
  endfunction

  function automatic logic [HashW-1:0] set_version(input logic [HashW-1:0] h);
    logic [HashW-1:0] r;
    r = h;
    r[15:12] = UuidVersion;
    return r;
  endfunction

  function automatic logic [HashW-1:0] set_variant(input logic [HashW-1:0] h);
    logic [HashW-1:0] r;
    r = h;
    r[63:62] = UuidVariant;
    return r;
  endfunction

endpackage

// ----- design/dfgh_if.sv -----
// Valid/ready channel interfaces for label bytes in and identifiers out.
// Depends on dfgh_pkg for the field widths.
interface dfgh_in_if;
  logic                         valid;
  logic                         ready;
  logic [dfgh_pkg::ByteW-1:0]   byte_value;
  logic                         has_byte;
  logic                         end_of_label;

  modport source (output valid, byte_value, has_byte, end_of_label, input ready);
  modport sink   (input valid, byte_value, has_byte, end_of_label, output ready);
endinterface

interface dfgh_out_if;
  logic                         valid;
  logic                         ready;
  logic [dfgh_pkg::HashW-1:0]   guid_upper;
  logic [dfgh_pkg::HashW-1:0]   guid_lower;

  modport source (output valid, guid_upper, guid_lower, input ready);
  modport sink   (input valid, guid_upper, guid_lower, output ready);
endinterface

// ----- design/dfgh_lane.sv -----
// One FNV-1a 64-bit hash lane: running hash register and its absorb logic.
// Depends on dfgh_pkg (fnv_mul, lane_ctrl_t).
module dfgh_lane #(
  parameter logic [dfgh_pkg::HashW-1:0] StartValue = dfgh_pkg::StartFirst
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  dfgh_pkg::lane_ctrl_t       ctrl_i,
  input  logic [dfgh_pkg::ByteW-1:0] byte_i,
  output logic [dfgh_pkg::HashW-1:0] hash_o,
  output logic [dfgh_pkg::HashW-1:0] hash_next_o
);

  logic [dfgh_pkg::HashW-1:0] hash_q, hash_d, absorbed;

  always_comb begin
    absorbed = hash_q;
    if (ctrl_i.take) begin
      absorbed = dfgh_pkg::fnv_mul(hash_q ^ {{(dfgh_pkg::HashW-dfgh_pkg::ByteW){1'b0}}, byte_i});
    end
  end

  // On advance, fold the held item in, or restart the lane once the label has been folded in.
  always_comb begin
    hash_d = hash_q;
    if (ctrl_i.advance) begin
      hash_d = ctrl_i.restart ? StartValue : absorbed;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= StartValue;
    end else begin
      hash_q <= hash_d;
    end
  end

  assign hash_o      = hash_q;
  assign hash_next_o = absorbed;

endmodule

// ----- design/dual_fnv_guid_hash.sv -----
// Dual FNV-1a name-based 128-bit identifier: label bytes in, one identifier per label out.
// Input register, then result register; one item per cycle when not stalled.
// Reset (async, active low) empties both stages and loads both hash lanes with their start
// values; a held result stalls input only when the held item ends a label.
// Depends on dfgh_pkg, dfgh_if and dfgh_lane.
module dual_fnv_guid_hash (
  input  logic         clk_i,
  input  logic         rst_ni,
  dfgh_in_if.sink      in_i,
  dfgh_out_if.source   out_o
);

  // Input register: holds one accepted item until it can fold into the lanes.
  logic                       s1_valid_q;
  logic [dfgh_pkg::ByteW-1:0] s1_byte_q;
  logic                       s1_has_q;
  logic                       s1_end_q;
  logic                       s1_adv;
  logic                       in_xfer;

  // Result register.
  logic                       out_valid_q, out_valid_d;
  logic [dfgh_pkg::HashW-1:0] upper_q, lower_q;

  dfgh_pkg::lane_ctrl_t       lane_ctrl;
  logic [dfgh_pkg::HashW-1:0] first_hash, first_next;
  logic [dfgh_pkg::HashW-1:0] second_hash, second_next;

  // An item that ends a label needs a free result slot; others always advance.
  assign s1_adv   = s1_valid_q && (!s1_end_q || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_xfer  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Payload: capture on transfer only.
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_byte_q <= in_i.byte_value;
      s1_has_q  <= in_i.has_byte;
      s1_end_q  <= in_i.end_of_label;
    end
  end

  always_comb begin
    lane_ctrl.advance = s1_adv;
    lane_ctrl.take    = s1_has_q;
    lane_ctrl.restart = s1_end_q;
  end

  dfgh_lane #(.StartValue(dfgh_pkg::StartFirst)) u_lane_first (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl),
    .byte_i      (s1_byte_q),
    .hash_o      (first_hash),
    .hash_next_o (first_next)
  );

  dfgh_lane #(.StartValue(dfgh_pkg::StartSecond)) u_lane_second (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (lane_ctrl),
    .byte_i      (s1_byte_q),
    .hash_o      (second_hash),
    .hash_next_o (second_next)
  );

  // Load a fresh identifier when a label ends; drop the old one once transferred.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_adv && s1_end_q) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_end_q) begin
      upper_q <= dfgh_pkg::set_version(first_next);
      lower_q <= dfgh_pkg::set_variant(second_next);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.guid_upper = upper_q;
  assign out_o.guid_lower = lower_q;

  // Both lanes sit at their start values right after a label completes.
  a_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_end_q |=> first_hash == dfgh_pkg::StartFirst &&
                           second_hash == dfgh_pkg::StartSecond)
    else $error("hash lanes did not restart after end of label");

  // A result appears only from an ending item that advanced.
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_end_q))
    else $error("result valid without a completed label");

  // Input stalls only behind an ending item blocked by a held result.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> s1_valid_q && s1_end_q && out_valid_q && !out_o.ready)
    else $error("input stalled without cause");

  // Lanes do not move while the held item waits.
  a_lane_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> $stable(first_hash) && $stable(second_hash))
    else $error("hash lane changed during stall");

  // Version and variant fields are forced on every valid result.
  a_uuid_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> upper_q[15:12] == dfgh_pkg::UuidVersion &&
                    lower_q[63:62] == dfgh_pkg::UuidVariant)
    else $error("identifier version or variant bits wrong");

endmodule

// ----- tb/sv/dfgh_guid_check.sv -----
// Transfer monitor and identifier predictor for the dual FNV-1a hash block.
// Depends on dfgh_pkg for widths and on dfgh_if for the two channel interfaces.
module dfgh_guid_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  dfgh_in_if          in_i,
  dfgh_out_if         out_i,
  output int unsigned mismatch_o,
  output int unsigned pending_o,
  output int unsigned guids_o
);

  localparam logic [dfgh_pkg::HashW-1:0] FNV_BASIS   = 64'hcbf29ce484222325;
  localparam logic [dfgh_pkg::HashW-1:0] FNV_PRIME   = 64'h00000100000001b3;
  localparam logic [dfgh_pkg::HashW-1:0] LANE_A_SEED = 64'h4e4c535f47554944;
  localparam logic [dfgh_pkg::HashW-1:0] LANE_B_SEED = 64'h646975675f534c4e;
  localparam logic [dfgh_pkg::HashW-1:0] LANE_A_INIT = FNV_BASIS ^ LANE_A_SEED;
  localparam logic [dfgh_pkg::HashW-1:0] LANE_B_INIT = FNV_BASIS ^ LANE_B_SEED;
  localparam logic [3:0]                 VERSION_NIB = 4'b0100;
  localparam logic [1:0]                 VARIANT_TOP = 2'b10;

  typedef struct packed {
    logic [dfgh_pkg::HashW-1:0] upper;
    logic [dfgh_pkg::HashW-1:0] lower;
  } guid_t;

  logic [dfgh_pkg::HashW-1:0] lane_a;
  logic [dfgh_pkg::HashW-1:0] lane_b;
  guid_t                      guid_q[$];

  function automatic logic [dfgh_pkg::HashW-1:0] fnv1a_absorb(
    input logic [dfgh_pkg::HashW-1:0] h,
    input logic [dfgh_pkg::ByteW-1:0] b
  );
    logic [dfgh_pkg::HashW-1:0] mixed;
    mixed = h ^ {{(dfgh_pkg::HashW-dfgh_pkg::ByteW){1'b0}}, b};
    return mixed * FNV_PRIME;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    guid_t fresh;
    guid_t want;
    if (!rst_ni) begin
      lane_a     = LANE_A_INIT;
      lane_b     = LANE_B_INIT;
      guid_q.delete();
      mismatch_o = 0;
      pending_o  = 0;
      guids_o    = 0;
    end else begin
      // predict first, so a result can never be checked before its label lands
      if (in_i.valid && in_i.ready) begin
        if (in_i.has_byte) begin
          lane_a = fnv1a_absorb(lane_a, in_i.byte_value);
          lane_b = fnv1a_absorb(lane_b, in_i.byte_value);
        end
        if (in_i.end_of_label) begin
          fresh.upper = {lane_a[63:16], VERSION_NIB, lane_a[11:0]};
          fresh.lower = {VARIANT_TOP, lane_b[61:0]};
          guid_q = {guid_q, fresh};
          lane_a = LANE_A_INIT;
          lane_b = LANE_B_INIT;
        end
      end
      if (out_i.valid && out_i.ready) begin
        guids_o++;
        if (guid_q.size() == 0) begin
          $error("identifier with no label pending: guid_upper %h guid_lower %h",
                 out_i.guid_upper, out_i.guid_lower);
          mismatch_o++;
        end else begin
          want = guid_q.pop_front();
          if (out_i.guid_upper !== want.upper) begin
            $error("guid_upper: expected %h, actual %h", want.upper, out_i.guid_upper);
            mismatch_o++;
          end
          if (out_i.guid_lower !== want.lower) begin
            $error("guid_lower: expected %h, actual %h", want.lower, out_i.guid_lower);
            mismatch_o++;
          end
        end
      end
      pending_o = guid_q.size();
    end
  end

endmodule

// ----- tb/sv/tb_top.sv -----
// Top-level bench for dual_fnv_guid_hash: clock, reset, label stimulus and verdict.
// Depends on dfgh_pkg, dfgh_if, the block itself and dfgh_guid_check.
module tb_top;

  // Run shape: directed labels first, then random labels until the item target is met.
  localparam int unsigned ITEM_TARGET = 360;
  // Settling time for the tail once every predicted identifier has come out.
  localparam int unsigned DRAIN_CYCLES = 8;
  // Slowest legal quiet stretch is the longest sender gap plus the longest receiver
  // stall plus the pass through the block; this is many times that.
  localparam int unsigned IDLE_LIMIT = 2000;

  logic clk_i = 1'b0;
  logic rst_ni;

  dfgh_in_if  in_if ();
  dfgh_out_if out_if ();

  int unsigned mismatches;
  int unsigned guids_pending;
  int unsigned guids_checked;

  int unsigned items_sent;    // transfers that carry a byte or end a label
  int unsigned fillers_sent;  // empty mid-label transfers, ignored by the block
  int unsigned labels_sent;
  int unsigned idle_cycles;
  logic        tx_calm;       // sender runs back to back while set
  logic        rx_calm;       // receiver never stalls while set

  dual_fnv_guid_hash dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dfgh_guid_check u_guid_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_i      (out_if),
    .mismatch_o (mismatches),
    .pending_o  (guids_pending),
    .guids_o    (guids_checked)
  );

  always #4 clk_i = ~clk_i;

  // Watchdog: count cycles with no transfer on either channel.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: %0d cycles without a transfer", idle_cycles);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Drive one input transfer. Called at a falling edge, returns at the falling
  // edge after the transfer. Valid is only lowered when a gap is drawn, so a
  // back-to-back item never sees valid dropped and raised in the same step.
  task automatic send_item(input logic [7:0] b, input logic has, input logic eol);
    int unsigned gap;
    gap = tx_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.byte_value   <= b;
    in_if.has_byte     <= has;
    in_if.end_of_label <= eol;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    if (has || eol) items_sent++;
    else fillers_sent++;
    if (eol) labels_sent++;
    @(negedge clk_i);
  endtask

  // Hold the sender off until every predicted identifier has come out.
  task automatic drain_guids();
    in_if.valid <= 1'b0;
    do @(negedge clk_i); while (guids_pending != 0);
  endtask

  // One random label: optional empty fillers before any byte, and the end marker
  // either rides on the last byte or comes as an empty item of its own.
  task automatic send_label(input int unsigned n_bytes);
    int unsigned i;
    logic        tail_on_byte;
    tail_on_byte = (n_bytes > 0) && ($urandom_range(0, 1) == 1);
    for (i = 0; i < n_bytes; i++) begin
      if ($urandom_range(0, 7) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_item(8'($urandom_range(0, 255)), 1'b1, tail_on_byte && (i == n_bytes - 1));
    end
    if (!tail_on_byte) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Receiver: per identifier, draw a random stall unless calm, then take it. Every so many
  // identifiers, redraw whether the next stretch runs without stalls.
  initial begin
    int unsigned stall;
    int unsigned taken;
    out_if.ready = 1'b0;
    rx_calm      = 1'b0;
    taken        = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (taken % 16 == 0) rx_calm = ($urandom_range(0, 2) == 0);
      stall = rx_calm ? 0 : $urandom_range(0, 15);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      taken++;
    end
  end

  // Stimulus and verdict.
  initial begin
    int unsigned len;
    logic        drained_mid;
    in_if.valid        = 1'b0;
    in_if.byte_value   = '0;
    in_if.has_byte     = 1'b0;
    in_if.end_of_label = 1'b0;
    rst_ni             = 1'b0;
    idle_cycles        = 0;
    items_sent         = 0;
    fillers_sent       = 0;
    labels_sent        = 0;
    tx_calm            = 1'b0;
    drained_mid        = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: empty label straight out of reset gives the bare start values.
    send_item(8'h00, 1'b0, 1'b1);
    // Single-byte labels at both ends of the byte range.
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    // Empty items mid-label must leave the hashes alone, whatever byte they hold.
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'ha5, 1'b1, 1'b0);
    send_item(8'h3c, 1'b0, 1'b0);
    send_item(8'hc3, 1'b1, 1'b1);
    // Plain three-byte label.
    tx_calm = 1'b1;
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b1, 1'b1);
    tx_calm = 1'b0;
    // Label closed by an empty end item that carries a byte to be ignored.
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7f, 1'b1, 1'b0);
    send_item(8'hff, 1'b0, 1'b1);
    // Back-to-back empty labels, then a one-byte label, check the return to start values.
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h01, 1'b1, 1'b1);
    drain_guids();

    // Random labels: mostly short, now and then long, one guaranteed long one.
    while (items_sent < ITEM_TARGET) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      if (labels_sent == 24) len = 48;
      else if ($urandom_range(0, 15) == 0) len = $urandom_range(9, 40);
      else len = $urandom_range(0, 8);
      send_label(len);
      // Hold the sender once in the middle until the pipe is empty.
      if (!drained_mid && items_sent >= ITEM_TARGET / 2) begin
        drain_guids();
        drained_mid = 1'b1;
      end
    end

    in_if.valid <= 1'b0;
    while (guids_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    if (guids_pending != 0) begin
      $error("%0d predicted identifiers never came out", guids_pending);
    end
    $display("covered %0d labels over %0d byte/end transfers and %0d empty fillers",
             labels_sent, items_sent, fillers_sent);
    $display("compared %0d identifiers, %0d field mismatches", guids_checked, mismatches);
    if (mismatches == 0 && guids_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/dfgh_pkg.sv
design/dfgh_if.sv
design/dfgh_lane.sv
design/dual_fnv_guid_hash.sv
tb/sv/dfgh_guid_check.sv
tb/sv/tb_top.sv
